>>> design/tfm_pkg.sv
package tfm_pkg;

	localparam int MAX_LAYERS    = 8;
	localparam int MAX_LAYER_LEN = 64;

	localparam int LIDX_W  = $clog2(MAX_LAYERS + 1);
	localparam int LADDR_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int POS_W   = $clog2(MAX_LAYER_LEN + 1);
	localparam int LEN_W   = $clog2(MAX_LAYER_LEN);
	localparam int ADDR_W  = LADDR_W + LEN_W;
	localparam int DEPTH   = 1 << ADDR_W;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_HASH  = 8'h23;

	typedef enum logic [1:0] {
		K_PLAIN = 2'd0,
		K_PLUS  = 2'd1,
		K_HASH  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		V_UNDECIDED = 2'd0,
		V_MATCH     = 2'd1,
		V_FAIL      = 2'd2
	} verdict_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} char_req_t;

	typedef struct packed {
		logic valid;
		logic matched;
		logic too_long;
	} result_t;

endpackage

>>> design/tfm_char_store.sv
module tfm_char_store (
	input  logic               clk,
	input  logic               arst_n,
	input  tfm_pkg::char_req_t req,
	output logic               mismatch
);
	import tfm_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_s1;
	logic [7:0] char_s1;
	logic       rvalid_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.data;
		end
		if (req.re) begin
			rdata_s1 <= mem[req.addr];
			char_s1  <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= req.re;
		end
	end

	assign mismatch = rvalid_s1 && (rdata_s1 != char_s1);

`ifndef SYNTH
	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.we && req.re))
		else $error("char store read and write in one cycle");
`endif

endmodule

>>> design/tfm_ctrl.sv
module tfm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic               mode,
	input  logic [7:0]         char_code,
	input  logic               mismatch,
	output tfm_pkg::char_req_t req,
	output tfm_pkg::result_t   res
);
	import tfm_pkg::*;

	logic [LEN_W-1:0] len_q [MAX_LAYERS];
	kind_t            kind_q [MAX_LAYERS];

	logic [LIDX_W-1:0] cnt_q, cnt_n;
	logic              ftl_q, ftl_n;
	logic              hlast_q, hlast_n;
	logic [LIDX_W-1:0] li_q, li_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic              in_q, in_n;
	logic              lse_q, lse_n;
	verdict_t          verd_q, verd_n;
	logic              ttl_q, ttl_n;

	logic              lse_eff;
	logic              lok;
	logic [LADDR_W-1:0] li_a;
	logic [LEN_W-1:0]  cur_len;
	kind_t             cur_kind;
	logic              len_we, kind_we;
	logic [LEN_W-1:0]  len_wd;
	kind_t             kind_wd;

	assign lse_eff  = lse_q && !mismatch;
	assign lok      = li_q < LIDX_W'(MAX_LAYERS);
	assign li_a     = li_q[LADDR_W-1:0];
	assign cur_len  = len_q[li_a];
	assign cur_kind = kind_q[li_a];

	always_comb begin
		logic [POS_W-1:0]  p;
		logic [POS_W-1:0]  p1;
		logic [LIDX_W-1:0] cl_li;
		logic              cl_in;
		logic [POS_W-1:0]  cl_pos;
		verdict_t          cl_v;
		verdict_t          vt;
		logic              err;

		cnt_n   = cnt_q;
		ftl_n   = ftl_q;
		hlast_n = hlast_q;
		li_n    = li_q;
		pos_n   = pos_q;
		in_n    = in_q;
		lse_n   = lse_eff;
		verd_n  = verd_q;
		ttl_n   = ttl_q;
		req     = '0;
		res     = '0;
		len_we  = 1'b0;
		kind_we = 1'b0;
		len_wd  = '0;
		kind_wd = K_PLAIN;
		vt      = verd_q;

		p   = in_q ? pos_q : '0;
		p1  = p + POS_W'(1);
		err = ftl_q || ttl_q;

		// layer close, shared by slash and end of string
		cl_li  = li_q;
		cl_in  = in_q;
		cl_pos = pos_q;
		cl_v   = verd_q;
		if (in_q) begin
			cl_in  = 1'b0;
			cl_pos = '0;
			if (lok) begin
				if (verd_q == V_UNDECIDED && li_q < cnt_q && cur_kind == K_PLAIN &&
				    !(lse_eff && pos_q == POS_W'(cur_len))) begin
					cl_v = V_FAIL;
				end
				cl_li = li_q + LIDX_W'(1);
			end
		end

		if (!mode) begin
			if (li_q == '0 && !in_q) begin
				cnt_n = '0;
				ftl_n = 1'b0;
			end
			if (char_code == CH_NUL) begin
				li_n   = '0;
				pos_n  = '0;
				in_n   = 1'b0;
				lse_n  = 1'b1;
				verd_n = V_UNDECIDED;
				ttl_n  = 1'b0;
			end else if (char_code == CH_SLASH) begin
				li_n  = cl_li;
				in_n  = cl_in;
				pos_n = cl_pos;
			end else begin
				if (!in_q) begin
					in_n = 1'b1;
					if (lok) begin
						cnt_n = li_q + LIDX_W'(1);
					end
				end
				if (lok) begin
					if (p1 >= POS_W'(MAX_LAYER_LEN)) begin
						ftl_n = 1'b1;
					end else begin
						req.we   = 1'b1;
						req.addr = {li_a, p[LEN_W-1:0]};
						req.data = char_code;
						len_we   = 1'b1;
						len_wd   = p1[LEN_W-1:0];
					end
					kind_we = 1'b1;
					if (p == '0 && char_code == CH_PLUS) begin
						kind_wd = K_PLUS;
					end else if (p == '0 && char_code == CH_HASH) begin
						kind_wd = K_HASH;
					end else begin
						kind_wd = K_PLAIN;
					end
					if (li_q + LIDX_W'(1) == cnt_n) begin
						hlast_n = (kind_wd == K_HASH);
					end
				end
				pos_n = (p < POS_W'(MAX_LAYER_LEN)) ? p1 : p;
			end
		end else begin
			if (char_code == CH_SLASH) begin
				li_n   = cl_li;
				in_n   = cl_in;
				pos_n  = cl_pos;
				verd_n = cl_v;
			end else if (char_code == CH_NUL) begin
				vt = cl_v;
				if (vt == V_UNDECIDED) begin
					if (cl_li == cnt_q) begin
						vt = V_MATCH;
					end else if (cl_li + LIDX_W'(1) == cnt_q && hlast_q) begin
						vt = V_MATCH;
					end else begin
						vt = V_FAIL;
					end
				end
				res.valid    = acc;
				res.matched  = (vt == V_MATCH) && !err;
				res.too_long = err;
				li_n   = '0;
				pos_n  = '0;
				in_n   = 1'b0;
				lse_n  = 1'b1;
				verd_n = V_UNDECIDED;
				ttl_n  = 1'b0;
			end else begin
				vt = verd_q;
				if (!in_q) begin
					in_n  = 1'b1;
					lse_n = 1'b1;
					if (lok && vt == V_UNDECIDED) begin
						if (li_q >= cnt_q) begin
							vt = V_FAIL;
						end else if (cur_kind == K_HASH) begin
							vt = (li_q + LIDX_W'(1) == cnt_q) ? V_MATCH : V_FAIL;
						end
					end
				end
				verd_n = vt;
				if (lok) begin
					if (p1 >= POS_W'(MAX_LAYER_LEN)) begin
						ttl_n = 1'b1;
					end
					if (vt == V_UNDECIDED && li_q < cnt_q && cur_kind == K_PLAIN) begin
						if (p >= POS_W'(cur_len) || p >= POS_W'(MAX_LAYER_LEN)) begin
							lse_n = 1'b0;
						end else begin
							req.re   = 1'b1;
							req.addr = {li_a, p[LEN_W-1:0]};
							req.data = char_code;
						end
					end
				end
				pos_n = (p < POS_W'(MAX_LAYER_LEN)) ? p1 : p;
			end
		end

		if (!acc) begin
			req.we  = 1'b0;
			req.re  = 1'b0;
			len_we  = 1'b0;
			kind_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_q[li_a] <= len_wd;
		end
		if (kind_we) begin
			kind_q[li_a] <= kind_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ftl_q   <= 1'b0;
			hlast_q <= 1'b0;
			li_q    <= '0;
			pos_q   <= '0;
			in_q    <= 1'b0;
			lse_q   <= 1'b1;
			verd_q  <= V_UNDECIDED;
			ttl_q   <= 1'b0;
		end else if (acc) begin
			cnt_q   <= cnt_n;
			ftl_q   <= ftl_n;
			hlast_q <= hlast_n;
			li_q    <= li_n;
			pos_q   <= pos_n;
			in_q    <= in_n;
			lse_q   <= lse_n;
			verd_q  <= verd_n;
			ttl_q   <= ttl_n;
		end else begin
			lse_q   <= lse_eff;
		end
	end

`ifndef SYNTH
	a_layer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		li_q <= LIDX_W'(MAX_LAYERS) && cnt_q <= LIDX_W'(MAX_LAYERS))
		else $error("layer counter out of range");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_LAYER_LEN))
		else $error("char position out of range");
	a_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_q |-> pos_q == '0)
		else $error("char position set outside a layer");
	a_result_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> (li_q == '0 && !in_q && verd_q == V_UNDECIDED && !ttl_q))
		else $error("counters not cleared after result");
`endif

endmodule

>>> design/topic_filter_matcher.sv
// MQTT-style topic filter matcher. Send the filter as bytes with tuser = 0, ended by a
// zero byte; send topic bytes with tuser = 1. The topic's zero byte returns one word:
// bit 0 matched, bit 1 layer too long. Filter words and non-terminating topic words
// return nothing. One byte is taken every cycle while the result register is free or
// being drained; the filter characters sit in a synchronous RAM whose registered read data
// feeds the compare, and a result is held in the output register from the cycle after its zero byte is taken.
module topic_filter_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tuser,   // [0] mode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] matched, [1] layer_too_long, [7:2] zero
);
	import tfm_pkg::*;

	logic      acc;
	logic      mismatch;
	char_req_t req;
	result_t   res;
	logic      out_valid_q;
	logic [1:0] out_data_q;

	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	tfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.mode      (s_tuser),
		.char_code (s_tdata),
		.mismatch  (mismatch),
		.req       (req),
		.res       (res)
	);

	tfm_char_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.mismatch (mismatch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q <= {res.too_long, res.matched};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_data_q};

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !res.valid)
		else $error("result register overwritten while held");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tfm_pkg::*;

	typedef struct packed {
		logic matched;
		logic too_long;
	} match_result_t;

	// positions written in every layer before random traffic starts
	localparam int FILL_W = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] char_code
	logic       s_tuser = 1'b0;    // [0] mode
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [0] matched, [1] layer_too_long, [7:2] zero

	// matcher state mirror
	logic [7:0]  flt_chars [MAX_LAYERS*MAX_LAYER_LEN];
	int unsigned flt_len [MAX_LAYERS];
	kind_t       flt_kind [MAX_LAYERS];
	int unsigned flt_count;
	logic        flt_err;
	int unsigned lyr;
	int unsigned pos;
	logic        in_lyr;
	logic        lyr_equal;
	verdict_t    verd;
	logic        tpc_err;

	match_result_t match_q[$];

	// random string builder: index 0 = filter, 1 = topic
	logic [7:0] seg [2][16][80];
	int         seg_len [2][16];
	int         seg_cnt [2];

	bit          src_gaps = 1'b1;
	bit          sink_stalls = 1'b1;
	int unsigned sink_hold = 0;
	int          n_words = 0;
	int          n_results = 0;
	int          n_matches = 0;
	int          n_flagged = 0;
	int          n_fail = 0;

	topic_filter_matcher u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void restart_scan();
		lyr       = 0;
		pos       = 0;
		in_lyr    = 1'b0;
		lyr_equal = 1'b1;
		verd      = V_UNDECIDED;
		tpc_err   = 1'b0;
	endfunction

	function automatic void end_layer(bit is_topic);
		if (!in_lyr)
			return;
		in_lyr = 1'b0;
		if (lyr < MAX_LAYERS) begin
			if (is_topic && verd == V_UNDECIDED && lyr < flt_count && flt_kind[lyr] == K_PLAIN &&
			    !(lyr_equal && pos == flt_len[lyr]))
				verd = V_FAIL;
			lyr = lyr + 1;
		end
		pos = 0;
	endfunction

	function automatic void store_filter_char(logic [7:0] c);
		if (!in_lyr) begin
			in_lyr = 1'b1;
			pos    = 0;
			if (lyr < MAX_LAYERS)
				flt_count = lyr + 1;
		end
		if (lyr < MAX_LAYERS) begin
			if (pos + 1 >= MAX_LAYER_LEN) begin
				flt_err = 1'b1;
			end else begin
				flt_chars[lyr*MAX_LAYER_LEN + pos] = c;
				flt_len[lyr] = pos + 1;
			end
			if (pos == 0)
				flt_kind[lyr] = (c == CH_PLUS) ? K_PLUS : (c == CH_HASH) ? K_HASH : K_PLAIN;
			else
				flt_kind[lyr] = K_PLAIN;
		end
		if (pos < MAX_LAYER_LEN)
			pos = pos + 1;
	endfunction

	function automatic void compare_topic_char(logic [7:0] c);
		if (!in_lyr) begin
			in_lyr    = 1'b1;
			pos       = 0;
			lyr_equal = 1'b1;
			if (lyr < MAX_LAYERS && verd == V_UNDECIDED) begin
				if (lyr >= flt_count)
					verd = V_FAIL;
				else if (flt_kind[lyr] == K_HASH)
					verd = (lyr + 1 == flt_count) ? V_MATCH : V_FAIL;
			end
		end
		if (lyr < MAX_LAYERS) begin
			if (pos + 1 >= MAX_LAYER_LEN)
				tpc_err = 1'b1;
			if (verd == V_UNDECIDED && lyr < flt_count && flt_kind[lyr] == K_PLAIN) begin
				if (pos >= flt_len[lyr] || pos >= MAX_LAYER_LEN)
					lyr_equal = 1'b0;
				else if (flt_chars[lyr*MAX_LAYER_LEN + pos] != c)
					lyr_equal = 1'b0;
			end
		end
		if (pos < MAX_LAYER_LEN)
			pos = pos + 1;
	endfunction

	function automatic void advance_matcher(logic mode, logic [7:0] c);
		match_result_t r;
		if (!mode) begin
			if (lyr == 0 && !in_lyr) begin
				flt_count = 0;
				flt_err   = 1'b0;
			end
			if (c == CH_NUL) begin
				end_layer(1'b0);
				restart_scan();
			end else if (c == CH_SLASH) begin
				end_layer(1'b0);
			end else begin
				store_filter_char(c);
			end
		end else if (c == CH_SLASH) begin
			end_layer(1'b1);
		end else if (c != CH_NUL) begin
			compare_topic_char(c);
		end else begin
			end_layer(1'b1);
			if (verd == V_UNDECIDED) begin
				if (lyr == flt_count)
					verd = V_MATCH;
				else if (lyr + 1 == flt_count && lyr < MAX_LAYERS && flt_kind[lyr] == K_HASH)
					verd = V_MATCH;
				else
					verd = V_FAIL;
			end
			r.too_long = flt_err | tpc_err;
			r.matched  = (verd == V_MATCH) && !r.too_long;
			match_q.push_back(r);
			restart_scan();
		end
	endfunction

	task automatic send_word(input logic mode, input logic [7:0] c);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_matcher(mode, c);
		n_words++;
	endtask

	task automatic send_text(input logic mode, input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_word(mode, s[i]);
		if (close)
			send_word(mode, CH_NUL);
	endtask

	// layers of printable bytes; flip_at toggles bit 0 of one byte
	task automatic send_wide(input logic mode, input int n_lyr, input int width, input int flip_at);
		logic [7:0] c;
		for (int l = 0; l < n_lyr; l++) begin
			if (l > 0)
				send_word(mode, CH_SLASH);
			for (int i = 0; i < width; i++) begin
				c = 8'h30 + 8'((l*7 + i) % 64);
				if (l*width + i == flip_at)
					c = c ^ 8'h01;
				send_word(mode, c);
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (match_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			m_tready  <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
			sink_hold <= $urandom_range(0, 10);
			m_tready  <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		match_result_t want;
		if (m_tvalid && m_tready) begin
			n_results++;
			if (m_tdata[0])
				n_matches++;
			if (m_tdata[1])
				n_flagged++;
			if (match_q.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				n_fail++;
			end else begin
				want = match_q.pop_front();
				if (m_tdata[0] !== want.matched) begin
					$error("matched: expected %0b, got %0b", want.matched, m_tdata[0]);
					n_fail++;
				end
				if (m_tdata[1] !== want.too_long) begin
					$error("layer_too_long: expected %0b, got %0b", want.too_long, m_tdata[1]);
					n_fail++;
				end
				if (m_tdata[7:2] !== 6'd0) begin
					$error("pad: expected 0, got %h", m_tdata[7:2]);
					n_fail++;
				end
			end
		end
	end

	function automatic logic [7:0] rand_char();
		logic [7:0] c;
		if ($urandom_range(0, 9) != 0)
			return 8'h61 + 8'($urandom_range(0, 1));
		c = 8'($urandom_range(1, 255));
		if (c == CH_SLASH)
			c = CH_PLUS;
		return c;
	endfunction

	function automatic int rand_len();
		return ($urandom_range(0, 29) == 0) ? $urandom_range(62, 66) : $urandom_range(1, 3);
	endfunction

	function automatic void fill_plain(int k, int l, int len);
		for (int j = 0; j < len; j++)
			seg[k][l][j] = rand_char();
		seg_len[k][l] = len;
	endfunction

	function automatic void make_filter();
		int n;
		int r;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 4);
		for (int l = 0; l < n; l++) begin
			r = $urandom_range(0, 11);
			if ((l == n - 1 && r < 3) || r == 3) begin
				seg[0][l][0] = CH_HASH;
				seg_len[0][l] = 1;
			end else if (r < 6) begin
				seg[0][l][0] = CH_PLUS;
				seg_len[0][l] = 1;
			end else begin
				fill_plain(0, l, rand_len());
			end
		end
		seg_cnt[0] = n;
	endfunction

	function automatic void make_topic();
		int n;
		int l;
		int j;
		if ($urandom_range(0, 3) == 0) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 4);
			for (l = 0; l < n; l++)
				fill_plain(1, l, rand_len());
			seg_cnt[1] = n;
			return;
		end
		// mostly follow the filter so that compares run deep
		n = 0;
		for (l = 0; l < seg_cnt[0]; l++) begin
			if (seg_len[0][l] == 1 && seg[0][l][0] == CH_PLUS) begin
				fill_plain(1, n, $urandom_range(1, 3));
				n++;
			end else if (seg_len[0][l] == 1 && seg[0][l][0] == CH_HASH && l == seg_cnt[0] - 1) begin
				repeat ($urandom_range(0, 3)) begin
					fill_plain(1, n, $urandom_range(1, 3));
					n++;
				end
			end else begin
				for (j = 0; j < seg_len[0][l]; j++)
					seg[1][n][j] = seg[0][l][j];
				seg_len[1][n] = seg_len[0][l];
				n++;
			end
		end
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 3))
				0: if (n > 0) begin
					l = $urandom_range(0, n - 1);
					j = $urandom_range(0, seg_len[1][l] - 1);
					seg[1][l][j] = seg[1][l][j] ^ 8'h01;
					if (seg[1][l][j] == CH_SLASH || seg[1][l][j] == CH_NUL)
						seg[1][l][j] = 8'h7A;
				end
				1: if (n > 0) begin
					n--;
				end
				2: begin
					fill_plain(1, n, $urandom_range(1, 3));
					n++;
				end
				default: if (n > 0) begin
					l = $urandom_range(0, n - 1);
					seg[1][l][seg_len[1][l]] = rand_char();
					seg_len[1][l]++;
				end
			endcase
		end
		seg_cnt[1] = n;
	endfunction

	task automatic send_segments(input bit k);
		if ($urandom_range(0, 3) == 0)
			send_word(k, CH_SLASH);
		for (int l = 0; l < seg_cnt[k]; l++) begin
			if (l > 0) begin
				send_word(k, CH_SLASH);
				if ($urandom_range(0, 4) == 0)
					send_word(k, CH_SLASH);
			end
			for (int j = 0; j < seg_len[k][l]; j++)
				send_word(k, seg[k][l][j]);
		end
		if ($urandom_range(0, 4) == 0)
			send_word(k, CH_SLASH);
		send_word(k, CH_NUL);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8))
			send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) != 0)
			send_word(1'b1, CH_NUL);
	endtask

	task automatic run_random(input int words);
		int start;
		start = n_words;
		while (n_words - start < words) begin
			make_filter();
			send_segments(1'b0);
			repeat ($urandom_range(1, 4)) begin
				make_topic();
				send_segments(1'b1);
			end
			if ($urandom_range(0, 9) == 0)
				send_noise();
		end
	endtask

	task automatic test_empty_filter();
		send_text(1'b1, "", 1'b1);
		send_text(1'b1, "/", 1'b1);
		send_text(1'b1, "a", 1'b1);
		settle();
	endtask

	// also fills the low positions of every layer before any compare can reach them
	task automatic test_layer_limits();
		send_wide(1'b0, MAX_LAYERS, FILL_W, -1);
		send_word(1'b0, CH_SLASH);
		send_wide(1'b0, 2, 4, -1);
		send_text(1'b0, "", 1'b1);
		send_wide(1'b1, MAX_LAYERS, FILL_W, -1);
		send_word(1'b1, CH_SLASH);
		send_wide(1'b1, 1, MAX_LAYER_LEN + 1, -1);
		send_text(1'b1, "", 1'b1);
		send_wide(1'b1, 1, MAX_LAYER_LEN, -1);
		send_text(1'b1, "", 1'b1);
		send_text(1'b0, "a/", 1'b0);
		send_wide(1'b0, 1, MAX_LAYER_LEN, -1);
		send_text(1'b0, "", 1'b1);
		send_text(1'b1, "a", 1'b1);
		settle();
	endtask

	task automatic test_wildcards();
		send_text(1'b0, "+/x/#", 1'b1);
		send_text(1'b1, "a/x", 1'b1);
		send_text(1'b1, "//q//x///", 1'b1);
		send_text(1'b1, "a/x/b/c", 1'b1);
		send_text(1'b1, "a/y/b", 1'b1);
		send_text(1'b0, "#", 1'b1);
		send_text(1'b1, "", 1'b1);
		send_text(1'b1, "a/b", 1'b1);
		send_text(1'b0, "a/#/b", 1'b1);
		send_text(1'b1, "a/q/b", 1'b1);
		send_text(1'b0, "+", 1'b1);
		send_text(1'b1, "", 1'b1);
		send_text(1'b0, "a+/#x", 1'b1);
		send_text(1'b1, "a+/#x", 1'b1);
		settle();
	endtask

	task automatic test_mode_switch();
		send_text(1'b0, "\377\200/q", 1'b1);
		send_text(1'b1, "\377\200/q", 1'b1);
		send_text(1'b0, "ab/cd", 1'b1);
		send_text(1'b1, "ab/", 1'b0);
		send_word(1'b0, 8'h7A);
		send_text(1'b1, "cd", 1'b1);
		settle();
	endtask

	task automatic test_random_traffic();
		run_random(40);
		settle();
	endtask

	task automatic test_random_steady();
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		run_random(30);
		settle();
	endtask

	initial begin
		for (int i = 0; i < MAX_LAYERS*MAX_LAYER_LEN; i++)
			flt_chars[i] = 8'h00;
		for (int i = 0; i < MAX_LAYERS; i++) begin
			flt_len[i]  = 0;
			flt_kind[i] = K_PLAIN;
		end
		flt_count = 0;
		flt_err   = 1'b0;
		restart_scan();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_filter();
		test_layer_limits();
		test_wildcards();
		test_mode_switch();
		test_random_traffic();
		test_random_steady();
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes and checked %0d verdicts (%0d matches, %0d too-long flags).",
			n_words, n_results, n_matches, n_flagged);
		$display("Run covered empty filter, layer limits, wildcards, mode switches, random traffic.");
		if (n_fail == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Timeout with %0d verdicts outstanding", match_q.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
